// File: src/ole_pkg.sv
// Shared constants, codes and types of the ordered list engine.
// No dependencies; every other file but ole_ram refers to it by scoped names.
package ole_pkg;

    // List geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Port field widths
    localparam int CMD_W    = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [IDX_W:0]        idx_wide_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CMD_W-1:0]      op_t;
    typedef logic [STATUS_W-1:0]   status_t;
    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [WORD_W-1:0]     word_t;

    localparam idx_t      LAST_IDX   = idx_t'(DEPTH - 1);
    localparam idx_wide_t DEPTH_WIDE = idx_wide_t'(DEPTH);
    localparam cnt_t      DEPTH_CNT  = cnt_t'(DEPTH);

    // Command codes
    localparam op_t OP_ADD_FRONT = op_t'(0);
    localparam op_t OP_ADD_BACK  = op_t'(1);
    localparam op_t OP_REM_FRONT = op_t'(2);
    localparam op_t OP_REM_BACK  = op_t'(3);
    localparam op_t OP_INSERT    = op_t'(4);
    localparam op_t OP_REM_KEY   = op_t'(5);
    localparam op_t OP_FIND      = op_t'(6);

    // Status codes
    localparam status_t ST_OK        = status_t'(0);
    localparam status_t ST_EMPTY     = status_t'(1);
    localparam status_t ST_NOT_FOUND = status_t'(2);
    localparam status_t ST_FULL      = status_t'(3);

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    push_front;
        logic    push_back;
        logic    pop_front;
        logic    pop_back;
        logic    scan_start;
        logic    scan_step;
        logic    take_hit;
        logic    shift_prep;
        logic    shift_step;
        logic    place;
        logic    drop;
        logic    result;
        status_t res_status;
    } ole_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic hit;
        logic scan_end;
        logic shift_done;
    } ole_stat_t;

endpackage

// File: src/ole_req_if.sv
// Request channel of the ordered list engine: valid/ready plus command fields.
// Depends on ole_pkg.
interface ole_req_if;
    logic             valid;
    logic             ready;
    ole_pkg::op_t     command;
    ole_pkg::word_t   match_key;
    ole_pkg::word_t   item_value;

    modport source (output valid, command, match_key, item_value, input ready);
    modport sink   (input valid, command, match_key, item_value, output ready);
endinterface

// File: src/ole_rsp_if.sv
// Response channel of the ordered list engine: valid/ready plus result fields.
// Depends on ole_pkg.
interface ole_rsp_if;
    logic              valid;
    logic              ready;
    ole_pkg::status_t  status;
    ole_pkg::pos_t     match_position;
    ole_pkg::count_t   entry_count;

    modport source (output valid, status, match_position, entry_count, input ready);
    modport sink   (input valid, status, match_position, entry_count, output ready);
endinterface

// File: src/ordered_list_engine.sv
// Ordered list engine: top level joining controller and datapath.
// Front/back commands and the unused code go from decode straight to the result; a key
// search reads the entries from the front until one matches or all miss, and an insert or
// key remove then moves the entries after the match before placing or dropping the item.
// Requests are taken one at a time: the next only once the result has been handed over.
// Reset empties the list; the store keeps its contents, which are read only once written.
module ordered_list_engine (
    input  logic       clk,
    input  logic       rst_n,
    ole_req_if.sink    req,
    ole_rsp_if.source  rsp
);

    ole_pkg::ole_cmd_t  cmd;
    ole_pkg::ole_stat_t stat;

    ole_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ole_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .command        (req.command),
        .match_key      (req.match_key),
        .item_value     (req.item_value),
        .cmd            (cmd),
        .stat           (stat),
        .status         (rsp.status),
        .match_position (rsp.match_position),
        .entry_count    (rsp.entry_count)
    );

endmodule

// File: src/ole_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/ole_dpath.sv
// Datapath of the ordered list engine: circular entry store, head and count,
// scan and shift counters, request and result registers. Depends on ole_pkg, ole_ram.
module ole_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  ole_pkg::op_t       command,
    input  ole_pkg::word_t     match_key,
    input  ole_pkg::word_t     item_value,
    input  ole_pkg::ole_cmd_t  cmd,
    output ole_pkg::ole_stat_t stat,
    output ole_pkg::status_t   status,
    output ole_pkg::pos_t      match_position,
    output ole_pkg::count_t    entry_count
);

    // Map a position from the front to a store address
    function automatic ole_pkg::idx_t phys(ole_pkg::idx_t base, ole_pkg::idx_t lidx);
        ole_pkg::idx_wide_t sum;
        sum = {1'b0, base} + {1'b0, lidx};
        if (sum >= ole_pkg::DEPTH_WIDE)
        begin
            sum = sum - ole_pkg::DEPTH_WIDE;
        end
        return sum[ole_pkg::IDX_W-1:0];
    endfunction

    ole_pkg::op_t     op_reg;
    ole_pkg::data_t   key_reg;
    ole_pkg::data_t   val_reg;
    ole_pkg::idx_t    head_reg;
    ole_pkg::cnt_t    count_reg;
    ole_pkg::cnt_t    idx_reg;
    ole_pkg::cnt_t    sidx_reg;
    ole_pkg::cnt_t    rem_reg;
    ole_pkg::idx_t    pidx_reg;
    ole_pkg::idx_t    hit_reg;
    logic             pend_reg;
    ole_pkg::status_t status_reg;
    ole_pkg::pos_t    pos_reg;
    ole_pkg::count_t  cnt_out_reg;

    logic             ram_we;
    ole_pkg::idx_t    ram_waddr;
    ole_pkg::data_t   ram_wdata;
    logic             ram_re;
    ole_pkg::idx_t    ram_raddr;
    ole_pkg::data_t   ram_rdata;

    logic             empty;
    logic             full;
    logic             dir_up;
    logic             scan_more;
    logic             shift_more;
    ole_pkg::idx_t    head_dec;
    ole_pkg::idx_t    head_inc;

    ole_ram #(
        .WIDTH (ole_pkg::DATA_WIDTH),
        .DEPTH (ole_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Occupancy flags, scan and shift flags, and head neighbors
    assign empty      = (count_reg == '0);
    assign full       = (count_reg == ole_pkg::DEPTH_CNT);
    assign dir_up     = (op_reg == ole_pkg::OP_INSERT);
    assign scan_more  = (idx_reg != count_reg);
    assign shift_more = (rem_reg != '0);
    assign head_dec   = (head_reg == '0) ? ole_pkg::LAST_IDX : head_reg - ole_pkg::idx_t'(1);
    assign head_inc   = (head_reg == ole_pkg::LAST_IDX) ? '0 : head_reg + ole_pkg::idx_t'(1);

    // Status toward the controller
    always_comb
    begin
        stat.op         = op_reg;
        stat.empty      = empty;
        stat.full       = full;
        stat.hit        = pend_reg && (ram_rdata == key_reg);
        stat.scan_end   = !pend_reg && !scan_more;
        stat.shift_done = !pend_reg && !shift_more;
    end

    // Store write and read port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = val_reg;
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (cmd.push_front)
        begin
            ram_we    = 1'b1;
            ram_waddr = head_dec;
        end
        else if (cmd.push_back)
        begin
            ram_we    = 1'b1;
            ram_waddr = phys(head_reg, count_reg[ole_pkg::IDX_W-1:0]);
        end
        else if (cmd.place)
        begin
            ram_we    = 1'b1;
            ram_waddr = phys(head_reg, hit_reg + ole_pkg::idx_t'(1));
        end
        else if (cmd.shift_step && pend_reg)
        begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            ram_waddr = dir_up ? phys(head_reg, pidx_reg + ole_pkg::idx_t'(1))
                               : phys(head_reg, pidx_reg - ole_pkg::idx_t'(1));
        end

        if (cmd.scan_step && scan_more)
        begin
            ram_re    = 1'b1;
            ram_raddr = phys(head_reg, idx_reg[ole_pkg::IDX_W-1:0]);
        end
        else if (cmd.shift_step && shift_more)
        begin
            ram_re    = 1'b1;
            ram_raddr = phys(head_reg, sidx_reg[ole_pkg::IDX_W-1:0]);
        end
    end

    // List control state: head, count, read-pending flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.push_front)
            begin
                head_reg <= head_dec;
            end
            else if (cmd.pop_front)
            begin
                head_reg <= head_inc;
            end

            if (cmd.push_front || cmd.push_back || cmd.place)
            begin
                count_reg <= count_reg + ole_pkg::cnt_t'(1);
            end
            else if (cmd.pop_front || cmd.pop_back || cmd.drop)
            begin
                count_reg <= count_reg - ole_pkg::cnt_t'(1);
            end

            if (cmd.scan_start || cmd.take_hit)
            begin
                pend_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                pend_reg <= scan_more;
            end
            else if (cmd.shift_step)
            begin
                pend_reg <= shift_more;
            end
        end
    end

    // Request capture, scan and shift counters
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= command;
            key_reg <= ole_pkg::data_t'(match_key);
            val_reg <= ole_pkg::data_t'(item_value);
            hit_reg <= '0;
        end
        if (cmd.scan_start)
        begin
            idx_reg <= '0;
        end
        if (cmd.scan_step && scan_more)
        begin
            pidx_reg <= idx_reg[ole_pkg::IDX_W-1:0];
            idx_reg  <= idx_reg + ole_pkg::cnt_t'(1);
        end
        if (cmd.take_hit)
        begin
            hit_reg <= pidx_reg;
        end
        if (cmd.shift_prep)
        begin
            rem_reg  <= count_reg - ole_pkg::cnt_t'(hit_reg) - ole_pkg::cnt_t'(1);
            sidx_reg <= dir_up ? count_reg - ole_pkg::cnt_t'(1)
                               : ole_pkg::cnt_t'(hit_reg) + ole_pkg::cnt_t'(1);
        end
        if (cmd.shift_step && shift_more)
        begin
            pidx_reg <= sidx_reg[ole_pkg::IDX_W-1:0];
            sidx_reg <= dir_up ? sidx_reg - ole_pkg::cnt_t'(1) : sidx_reg + ole_pkg::cnt_t'(1);
            rem_reg  <= rem_reg - ole_pkg::cnt_t'(1);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            status_reg  <= cmd.res_status;
            pos_reg     <= ole_pkg::pos_t'(hit_reg);
            cnt_out_reg <= ole_pkg::count_t'(count_reg);
        end
    end

    assign status         = status_reg;
    assign match_position = pos_reg;
    assign entry_count    = cnt_out_reg;

    // Occupancy stays within the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ole_pkg::DEPTH_CNT)
        else $error("entry count beyond depth");

    // Adds only go to a list with room
    a_add_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_front || cmd.push_back || cmd.place) |-> !full)
        else $error("add to a full list");

    // Removes only come from a non-empty list, and shrink it by one
    a_remove_one: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop_front || cmd.pop_back || cmd.drop)
        |=> count_reg == $past(count_reg) - ole_pkg::cnt_t'(1) && $past(!empty))
        else $error("remove from an empty list");

endmodule

// File: src/ole_ctrl.sv
// Controller of the ordered list engine: sequences decode, key scan, shift
// and result hand-off. Depends on ole_pkg.
module ole_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ole_pkg::ole_stat_t stat,
    output ole_pkg::ole_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_PREP   = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    ole_pkg::status_t stat_reg;
    ole_pkg::status_t stat_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.res_status = stat_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    stat_next  = ole_pkg::ST_OK;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                case (stat.op)
                    ole_pkg::OP_ADD_FRONT:
                    begin
                        if (stat.full)
                        begin
                            stat_next = ole_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.push_front = 1'b1;
                        end
                    end
                    ole_pkg::OP_ADD_BACK:
                    begin
                        if (stat.full)
                        begin
                            stat_next = ole_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.push_back = 1'b1;
                        end
                    end
                    ole_pkg::OP_REM_FRONT:
                    begin
                        if (stat.empty)
                        begin
                            stat_next = ole_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.pop_front = 1'b1;
                        end
                    end
                    ole_pkg::OP_REM_BACK:
                    begin
                        if (stat.empty)
                        begin
                            stat_next = ole_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.pop_back = 1'b1;
                        end
                    end
                    ole_pkg::OP_INSERT, ole_pkg::OP_REM_KEY, ole_pkg::OP_FIND:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SEARCH;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SEARCH:
            begin
                if (stat.hit)
                begin
                    cmd.take_hit = 1'b1;
                    if (stat.op == ole_pkg::OP_FIND)
                    begin
                        state_next = S_DONE;
                    end
                    else if (stat.op == ole_pkg::OP_INSERT && stat.full)
                    begin
                        stat_next  = ole_pkg::ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
                else if (stat.scan_end)
                begin
                    stat_next  = ole_pkg::ST_NOT_FOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_PREP:
            begin
                cmd.shift_prep = 1'b1;
                state_next     = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    if (stat.op == ole_pkg::OP_INSERT)
                    begin
                        cmd.place = 1'b1;
                    end
                    else
                    begin
                        cmd.drop = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_DONE:
            begin
                // Hand the result over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.result     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, status code and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stat_reg      <= ole_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stat_reg      <= stat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A request always moves on to decode
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_DECODE)
        else $error("accepted request not decoded");

    // A result never overwrites one still waiting
    a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // A new result is presented right after it is loaded
    a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result |=> out_valid_reg && state_reg == S_IDLE)
        else $error("loaded result not presented");

endmodule
